// File: rtl/assert_macros.svh
// Assertion shorthands shared by the RTL files. Each expands to one labeled
// concurrent assertion on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ABB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ABB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/abb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abb_pkg
// Shared types and constants of the transformed box bound pipeline.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int QW        = 32;               // value width
  localparam int FRAC_BITS = 16;               // fraction bits, 8..24
  localparam int PROD_W    = 2 * QW;           // full product width
  localparam int TERM_W    = PROD_W - FRAC_BITS; // product after floor shift
  localparam int SUM_W     = TERM_W + 1;       // bound plus term, no wrap
  localparam int AXES      = 3;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [QW-1:0] coef_x;
    logic signed [QW-1:0] coef_y;
    logic signed [QW-1:0] coef_z;
    logic signed [QW-1:0] offset;
    logic signed [QW-1:0] lo_x;
    logic signed [QW-1:0] lo_y;
    logic signed [QW-1:0] lo_z;
    logic signed [QW-1:0] hi_x;
    logic signed [QW-1:0] hi_y;
    logic signed [QW-1:0] hi_z;
  } item_t;

  typedef struct packed {
    logic signed [QW-1:0] bound_low;
    logic signed [QW-1:0] bound_high;
    logic                 overflow;
  } result_t;

  // Sorted pair of truncated products for one source axis.
  typedef struct packed {
    logic signed [TERM_W-1:0] lo;
    logic signed [TERM_W-1:0] hi;
  } term_pair_t;

  // Running bounds plus the terms still to be added; terms[0] is next.
  typedef struct packed {
    logic signed [QW-1:0] low;
    logic signed [QW-1:0] high;
    logic                 ovf;
    term_pair_t [AXES-1:0] terms;
  } track_t;

endpackage

// File: rtl/abb_acc_stage.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// abb_acc_stage
// One saturating accumulate stage: add the next sorted term pair to the
// bounds, clamp to the 32-bit range, and shift the remaining terms down.
// ----------------------------------------------------------------------------
module abb_acc_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  abb_pkg::track_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output abb_pkg::track_t dn_data
);

  logic signed [abb_pkg::SUM_W-1:0] sum_low;
  logic signed [abb_pkg::SUM_W-1:0] sum_high;
  logic                             fit_low;
  logic                             fit_high;
  abb_pkg::track_t                  dn_data_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    sum_low  = abb_pkg::SUM_W'(up_data.low) +
               abb_pkg::SUM_W'(up_data.terms[0].lo);
    sum_high = abb_pkg::SUM_W'(up_data.high) +
               abb_pkg::SUM_W'(up_data.terms[0].hi);
    // in range when all bits above the value's sign bit match it
    fit_low  = (&sum_low[abb_pkg::SUM_W-1:abb_pkg::QW-1]) ||
               !(|sum_low[abb_pkg::SUM_W-1:abb_pkg::QW-1]);
    fit_high = (&sum_high[abb_pkg::SUM_W-1:abb_pkg::QW-1]) ||
               !(|sum_high[abb_pkg::SUM_W-1:abb_pkg::QW-1]);

    dn_data_next = up_data;
    if (fit_low) begin
      dn_data_next.low = sum_low[abb_pkg::QW-1:0];
    end else begin
      dn_data_next.low = sum_low[abb_pkg::SUM_W-1] ? abb_pkg::Q_MIN
                                                   : abb_pkg::Q_MAX;
    end
    if (fit_high) begin
      dn_data_next.high = sum_high[abb_pkg::QW-1:0];
    end else begin
      dn_data_next.high = sum_high[abb_pkg::SUM_W-1] ? abb_pkg::Q_MIN
                                                     : abb_pkg::Q_MAX;
    end
    dn_data_next.ovf = up_data.ovf || !fit_low || !fit_high;
    dn_data_next.terms = {abb_pkg::term_pair_t'('0),
                          up_data.terms[abb_pkg::AXES-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

  `ABB_ASSERT(a_load_shows, up_valid && up_ready |=> dn_valid,
              "loaded item not shown")
  `ABB_ASSERT(a_ovf_sticky, up_valid && up_ready && up_data.ovf |=> dn_data.ovf,
              "overflow lost")
  `ABB_ASSERT(a_stall_hold, dn_valid && !dn_ready |=> dn_valid && $stable(dn_data),
              "stalled item changed")
  `ABB_ASSERT_ALWAYS(a_reset_empty, rst |=> !dn_valid, "stage not empty after reset")

endmodule

// File: rtl/affine_box_bound_axis.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// affine_box_bound_axis
// One output axis of an affine-transformed axis-aligned box: per source axis,
// sort coefficient*min and coefficient*max and add them to saturating bounds.
// ----------------------------------------------------------------------------
// Pipeline: the accept edge loads the first of five stages (multiply, sort,
//   and one saturating add stage each for x, y and z); the last of them is
//   the output register.
// Throughput: one item per cycle while result_ready is high; every stage holds
//   one item and advances whenever the stage after it is empty or being drained.
// Reset: synchronous rst empties every stage; results in flight are dropped.
module affine_box_bound_axis (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  abb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output abb_pkg::result_t result
);

  // --------------------------------------------------------------------------
  // Stage 1: six full-width products and the translation.
  // --------------------------------------------------------------------------
  logic                               s1_valid;
  logic                               s1_ready;
  logic signed [abb_pkg::QW-1:0]      s1_offset;
  logic signed [abb_pkg::PROD_W-1:0]  s1_prod_a [abb_pkg::AXES];
  logic signed [abb_pkg::PROD_W-1:0]  s1_prod_b [abb_pkg::AXES];
  logic signed [abb_pkg::PROD_W-1:0]  prod_a_next [abb_pkg::AXES];
  logic signed [abb_pkg::PROD_W-1:0]  prod_b_next [abb_pkg::AXES];

  // Stage 2: floored products, sorted into low and high terms.
  logic                               s2_valid;
  logic                               s2_ready;
  abb_pkg::track_t                    s2_track;
  abb_pkg::track_t                    s2_track_next;

  // Add chain, x then y then z.
  logic                               acc_valid [abb_pkg::AXES];
  logic                               acc_ready [abb_pkg::AXES];
  abb_pkg::track_t                    acc_data  [abb_pkg::AXES];

  assign item_ready = s1_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign s2_ready   = !s2_valid || acc_ready[0];

  // 32x32 signed products; operands are sign-extended to the product width.
  always_comb begin
    prod_a_next[0] = abb_pkg::PROD_W'(item.coef_x) * abb_pkg::PROD_W'(item.lo_x);
    prod_a_next[1] = abb_pkg::PROD_W'(item.coef_y) * abb_pkg::PROD_W'(item.lo_y);
    prod_a_next[2] = abb_pkg::PROD_W'(item.coef_z) * abb_pkg::PROD_W'(item.lo_z);
    prod_b_next[0] = abb_pkg::PROD_W'(item.coef_x) * abb_pkg::PROD_W'(item.hi_x);
    prod_b_next[1] = abb_pkg::PROD_W'(item.coef_y) * abb_pkg::PROD_W'(item.hi_y);
    prod_b_next[2] = abb_pkg::PROD_W'(item.coef_z) * abb_pkg::PROD_W'(item.hi_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && item_valid) begin
      s1_offset <= item.offset;
      for (int k = 0; k < abb_pkg::AXES; k++) begin
        s1_prod_a[k] <= prod_a_next[k];
        s1_prod_b[k] <= prod_b_next[k];
      end
    end
  end

  // Drop the low fraction bits (floor), then send the smaller product to the
  // low bound; equal products go to both.
  always_comb begin
    logic signed [abb_pkg::TERM_W-1:0] ta;
    logic signed [abb_pkg::TERM_W-1:0] tb;
    s2_track_next.low  = s1_offset;
    s2_track_next.high = s1_offset;
    s2_track_next.ovf  = 1'b0;
    for (int k = 0; k < abb_pkg::AXES; k++) begin
      ta = s1_prod_a[k][abb_pkg::PROD_W-1:abb_pkg::FRAC_BITS];
      tb = s1_prod_b[k][abb_pkg::PROD_W-1:abb_pkg::FRAC_BITS];
      if (ta < tb) begin
        s2_track_next.terms[k].lo = ta;
        s2_track_next.terms[k].hi = tb;
      end else begin
        s2_track_next.terms[k].lo = tb;
        s2_track_next.terms[k].hi = ta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_track <= s2_track_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 to 5: one saturating add per source axis; the last stage is the
  // output register.
  // --------------------------------------------------------------------------
  abb_acc_stage u_acc_x (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (acc_ready[0]),
    .up_data  (s2_track),
    .dn_valid (acc_valid[0]),
    .dn_ready (acc_ready[1]),
    .dn_data  (acc_data[0])
  );

  abb_acc_stage u_acc_y (
    .clk      (clk),
    .rst      (rst),
    .up_valid (acc_valid[0]),
    .up_ready (acc_ready[1]),
    .up_data  (acc_data[0]),
    .dn_valid (acc_valid[1]),
    .dn_ready (acc_ready[2]),
    .dn_data  (acc_data[1])
  );

  abb_acc_stage u_acc_z (
    .clk      (clk),
    .rst      (rst),
    .up_valid (acc_valid[1]),
    .up_ready (acc_ready[2]),
    .up_data  (acc_data[1]),
    .dn_valid (acc_valid[2]),
    .dn_ready (result_ready),
    .dn_data  (acc_data[2])
  );

  assign result_valid      = acc_valid[2];
  assign result.bound_low  = acc_data[2].low;
  assign result.bound_high = acc_data[2].high;
  assign result.overflow   = acc_data[2].ovf;

  `ABB_ASSERT(a_sorted_x,
              s2_valid |-> s2_track.terms[0].lo <= s2_track.terms[0].hi,
              "x terms unsorted")
  `ABB_ASSERT(a_sorted_z,
              s2_valid |-> s2_track.terms[2].lo <= s2_track.terms[2].hi,
              "z terms unsorted")
  `ABB_ASSERT(a_bounds_order,
              result_valid && !result.overflow |-> result.bound_low <= result.bound_high,
              "low bound above high bound")

endmodule
